// ===== hw/rtl/ehp_pkg.sv =====
// shared types and constants for the ethernet / ipv4 / tcp / udp header parser
`default_nettype none

package ehp_pkg;

   localparam int POS_W = 16;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
   localparam logic [7:0]  MIN_HDR_LEN    = 8'd20;
   localparam logic [7:0]  UDP_HDR_LEN    = 8'd8;
   localparam logic [3:0]  NIBBLE_MASK    = 4'hF;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   // byte offsets inside the frame
   localparam logic [POS_W-1:0] OFS_ETYPE_HI = POS_W'(12);
   localparam logic [POS_W-1:0] OFS_ETYPE_LO = POS_W'(13);
   localparam logic [POS_W-1:0] OFS_VER_IHL  = POS_W'(14);
   localparam logic [POS_W-1:0] OFS_TP_MIN   = POS_W'(15);
   localparam logic [POS_W-1:0] OFS_PROTO    = POS_W'(23);
   localparam logic [POS_W-1:0] OFS_SRC      = POS_W'(26);
   localparam logic [POS_W-1:0] OFS_DST      = POS_W'(30);
   localparam logic [POS_W-1:0] OFS_DST_END  = POS_W'(34);

   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [2:0] {
      STAT_NON_IP     = 3'd0,
      STAT_IPV4_OTHER = 3'd1,
      STAT_TCP        = 3'd2,
      STAT_UDP        = 3'd3,
      STAT_REJECT     = 3'd4
   } status_type;

   // view of one frame after its last byte has been captured
   typedef struct packed {
      logic [15:0] len;
      logic [15:0] eth_type;
      logic [3:0]  version;
      logic [5:0]  ihl_bytes;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] ports;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [7:0]  flags;
      logic [5:0]  thb;
   } frame_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] eth_type;
      logic [7:0]  ip_protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [31:0] sequence_number;
      logic [31:0] ack_num;
      logic [7:0]  flag_bits;
      logic [7:0]  payload_start;
      logic [15:0] payload_bytes;
   } rec_type;

endpackage

`default_nettype wire

// ===== hw/rtl/eth_ipv4_l4_header_parser.sv =====
// top level of the byte-serial ethernet / ipv4 / tcp / udp header parser
// throughput: one byte word accepted every cycle while the result side keeps up
// the record for a frame passes through the frame snapshot register, then the result
//   register, before it is valid on rsp_
// reset: synchronous, active high; clears the position counter, the captured
//   fields and both valid flags
`default_nettype none

module eth_ipv4_l4_header_parser
   import ehp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_packet,
   // record output channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_eth_type,
   output logic [7:0]       rsp_ip_protocol,
   output logic [31:0]      rsp_source_address,
   output logic [31:0]      rsp_dest_address,
   output logic [15:0]      rsp_source_port,
   output logic [15:0]      rsp_dest_port,
   output logic [31:0]      rsp_sequence_number,
   output logic [31:0]      rsp_ack_num,
   output logic [7:0]       rsp_flag_bits,
   output logic [7:0]       rsp_payload_start,
   output logic [15:0]      rsp_payload_bytes
);

   // handshake and pipeline control
   logic      word_take;
   logic      snap_move;
   logic      snap_valid_ff, snap_valid_in;
   frame_type snap_ff;
   frame_type frame_next;
   rec_type   rec;
   logic      rsp_valid_ff, rsp_valid_in;
   rec_type   rsp_ff;

   // snapshot slot drains whenever the result register is empty or being taken
   assign snap_move = !rsp_valid_ff || !rsp_stall;
   // only a full snapshot slot that cannot drain holds off the byte stream
   assign req_stall = snap_valid_ff && !snap_move;
   assign word_take = req_valid && !req_stall;

   // running capture of the current frame
   ehp_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .word_take     (word_take),
      .data_byte     (req_data_byte),
      .end_of_packet (req_end_of_packet),
      .frame_next    (frame_next)
   );

   // snapshot of a finished frame, parsing state has already been cleared
   always_comb begin
      if (word_take && req_end_of_packet) begin
         snap_valid_in = 1'b1;
      end else if (snap_move) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_take && req_end_of_packet) begin
         snap_ff <= frame_next;
      end
   end

   // length checks and field selection
   ehp_record u_record (
      .frame (snap_ff),
      .rec   (rec)
   );

   // result register
   assign rsp_valid_in = snap_move ? snap_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_move && snap_valid_ff) begin
         rsp_ff <= rec;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_eth_type        = rsp_ff.eth_type;
   assign rsp_ip_protocol     = rsp_ff.ip_protocol;
   assign rsp_source_address  = rsp_ff.source_address;
   assign rsp_dest_address    = rsp_ff.dest_address;
   assign rsp_source_port     = rsp_ff.source_port;
   assign rsp_dest_port       = rsp_ff.dest_port;
   assign rsp_sequence_number = rsp_ff.sequence_number;
   assign rsp_ack_num         = rsp_ff.ack_num;
   assign rsp_flag_bits       = rsp_ff.flag_bits;
   assign rsp_payload_start   = rsp_ff.payload_start;
   assign rsp_payload_bytes   = rsp_ff.payload_bytes;

endmodule

`default_nettype wire

// ===== hw/rtl/ehp_capture.sv =====
// byte position counter and header field capture registers
`default_nettype none

module ehp_capture
   import ehp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       word_take,
   input  wire logic [7:0] data_byte,
   input  wire logic       end_of_packet,
   output frame_type       frame_next
);

   pos_type   pos_ff, pos_in;
   frame_type cap_ff, cap_in;
   logic [7:0]  tp_base;
   pos_type     rel;
   logic        tp_hit;

   always_comb begin
      cap_in = cap_ff;
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_W'(1);

      if (pos_ff == OFS_ETYPE_HI || pos_ff == OFS_ETYPE_LO) begin
         cap_in.eth_type = {cap_ff.eth_type[7:0], data_byte};
      end
      if (pos_ff == OFS_VER_IHL) begin
         cap_in.version   = data_byte[7:4] & NIBBLE_MASK;
         cap_in.ihl_bytes = {data_byte[3:0] & NIBBLE_MASK, 2'b00};
      end
      if (pos_ff == OFS_PROTO) begin
         cap_in.protocol = data_byte;
      end
      if (pos_ff >= OFS_SRC && pos_ff < OFS_DST) begin
         cap_in.src_addr = {cap_ff.src_addr[23:0], data_byte};
      end
      if (pos_ff >= OFS_DST && pos_ff < OFS_DST_END) begin
         cap_in.dst_addr = {cap_ff.dst_addr[23:0], data_byte};
      end

      // transport header sits right after the ip header
      tp_base = ETH_HDR_LEN + {2'b00, cap_ff.ihl_bytes};
      tp_hit  = (pos_ff >= OFS_TP_MIN) && (pos_ff >= POS_W'(tp_base));
      rel     = pos_ff - POS_W'(tp_base);
      if (tp_hit) begin
         if (rel < POS_W'(4)) begin
            cap_in.ports = {cap_ff.ports[23:0], data_byte};
         end else if (rel < POS_W'(8)) begin
            cap_in.seq = {cap_ff.seq[23:0], data_byte};
         end else if (rel < POS_W'(12)) begin
            cap_in.ack = {cap_ff.ack[23:0], data_byte};
         end else if (rel == POS_W'(12)) begin
            cap_in.thb = {data_byte[7:4] & NIBBLE_MASK, 2'b00};
         end else if (rel == POS_W'(13)) begin
            cap_in.flags = data_byte;
         end
      end

      // frame length counts this byte, saturating
      cap_in.len = 16'(pos_in);
   end

   assign frame_next = cap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         cap_ff <= '0;
      end else if (word_take) begin
         if (end_of_packet) begin
            pos_ff <= '0;
            cap_ff <= '0;
         end else begin
            pos_ff <= pos_in;
            cap_ff <= cap_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ehp_record.sv =====
// header checks and result record assembly for one completed frame
`default_nettype none

module ehp_record
   import ehp_pkg::*;
(
   input  wire frame_type frame,
   output rec_type        rec
);

   logic [7:0]  tp_base;
   logic [7:0]  tcp_end;
   logic [7:0]  start;
   logic        ok;
   status_type  status;

   always_comb begin
      rec     = '0;
      tp_base = ETH_HDR_LEN + {2'b00, frame.ihl_bytes};
      tcp_end = tp_base + {2'b00, frame.thb};
      start   = tp_base;
      ok      = 1'b0;
      status  = STAT_REJECT;

      if (frame.len < 16'(ETH_HDR_LEN)) begin
         ok = 1'b0;
      end else if (frame.eth_type != ETHERTYPE_IPV4) begin
         rec.eth_type = frame.eth_type;
         status       = STAT_NON_IP;
      end else if (frame.len < 16'(ETH_HDR_LEN + MIN_HDR_LEN) ||
                   frame.version != IP_VERSION_4 ||
                   {2'b00, frame.ihl_bytes} < MIN_HDR_LEN ||
                   16'(tp_base) > frame.len) begin
         ok = 1'b0;
      end else begin
         ok     = 1'b1;
         status = STAT_IPV4_OTHER;
         if (frame.protocol == PROTO_TCP) begin
            if (16'(tp_base + MIN_HDR_LEN) > frame.len ||
                {2'b00, frame.thb} < MIN_HDR_LEN ||
                16'(tcp_end) > frame.len) begin
               ok = 1'b0;
            end else begin
               status = STAT_TCP;
               start  = tcp_end;
            end
         end else if (frame.protocol == PROTO_UDP) begin
            if (16'(tp_base + UDP_HDR_LEN) > frame.len) begin
               ok = 1'b0;
            end else begin
               status = STAT_UDP;
               start  = tp_base + UDP_HDR_LEN;
            end
         end
         if (!ok) begin
            status = STAT_REJECT;
         end else begin
            rec.eth_type       = frame.eth_type;
            rec.ip_protocol    = frame.protocol;
            rec.source_address = frame.src_addr;
            rec.dest_address   = frame.dst_addr;
            if (status == STAT_TCP || status == STAT_UDP) begin
               rec.source_port = frame.ports[31:16];
               rec.dest_port   = frame.ports[15:0];
            end
            if (status == STAT_TCP) begin
               rec.sequence_number = frame.seq;
               rec.ack_num         = frame.ack;
               rec.flag_bits       = frame.flags;
            end
            rec.payload_start = start;
            rec.payload_bytes = (16'(start) < frame.len) ?
                                frame.len - 16'(start) : 16'd0;
         end
      end
      rec.status = status;
   end

endmodule

`default_nettype wire

// ===== verif/header_record_checker.sv =====
// byte-level predictor and record scoreboard for the header parser
`timescale 1ns / 1ps

module header_record_checker
   import ehp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_packet,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [15:0] rsp_eth_type,
   input  wire logic [7:0]  rsp_ip_protocol,
   input  wire logic [31:0] rsp_source_address,
   input  wire logic [31:0] rsp_dest_address,
   input  wire logic [15:0] rsp_source_port,
   input  wire logic [15:0] rsp_dest_port,
   input  wire logic [31:0] rsp_sequence_number,
   input  wire logic [31:0] rsp_ack_num,
   input  wire logic [7:0]  rsp_flag_bits,
   input  wire logic [7:0]  rsp_payload_start,
   input  wire logic [15:0] rsp_payload_bytes,
   output int               error_count,
   output int               records_pending
);

   // shadow of the parser's per-frame capture state
   pos_type     frame_pos;
   logic [15:0] etype_acc;
   logic [3:0]  ver_nib;
   logic [5:0]  ihl_len;
   logic [7:0]  proto_acc;
   logic [31:0] src_acc;
   logic [31:0] dst_acc;
   logic [31:0] ports_acc;
   logic [31:0] seq_acc;
   logic [31:0] ack_acc;
   logic [7:0]  flags_acc;
   logic [5:0]  tcp_hdr_len;

   rec_type     record_q[$];
   rec_type     want_rec;
   int          errors = 0;
   int          rec_no = 0;

   assign error_count = errors;

   task automatic clear_frame();
      frame_pos   = '0;
      etype_acc   = '0;
      ver_nib     = '0;
      ihl_len     = '0;
      proto_acc   = '0;
      src_acc     = '0;
      dst_acc     = '0;
      ports_acc   = '0;
      seq_acc     = '0;
      ack_acc     = '0;
      flags_acc   = '0;
      tcp_hdr_len = '0;
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      int unsigned p;
      int unsigned l4_ofs;
      int unsigned rel;
      p = frame_pos;
      if (p == OFS_ETYPE_HI || p == OFS_ETYPE_LO) etype_acc = {etype_acc[7:0], b};
      if (p == OFS_VER_IHL) begin
         ver_nib = b[7:4];
         ihl_len = {b[3:0], 2'b00};
      end
      if (p == OFS_PROTO) proto_acc = b;
      if (p >= OFS_SRC && p < OFS_DST) src_acc = {src_acc[23:0], b};
      if (p >= OFS_DST && p < OFS_DST_END) dst_acc = {dst_acc[23:0], b};
      // transport header sits right after the ip header, wherever ihl puts it
      l4_ofs = int'(ETH_HDR_LEN) + int'(ihl_len);
      if (p >= OFS_TP_MIN && p >= l4_ofs) begin
         rel = p - l4_ofs;
         if (rel < 4) ports_acc = {ports_acc[23:0], b};
         else if (rel < 8) seq_acc = {seq_acc[23:0], b};
         else if (rel < 12) ack_acc = {ack_acc[23:0], b};
         else if (rel == 12) tcp_hdr_len = {b[7:4], 2'b00};
         else if (rel == 13) flags_acc = b;
      end
   endtask

   function automatic rec_type frame_record();
      rec_type     r;
      int unsigned frame_len;
      int unsigned l4_ofs;
      int unsigned pay_ofs;
      r = '0;
      r.status = STAT_REJECT;
      frame_len = int'(frame_pos) + 1;
      if (frame_len > POS_MAX) frame_len = POS_MAX;
      if (frame_len < ETH_HDR_LEN) return r;
      if (etype_acc != ETHERTYPE_IPV4) begin
         r.status = STAT_NON_IP;
         r.eth_type = etype_acc;
         return r;
      end
      if (frame_len < int'(ETH_HDR_LEN) + int'(MIN_HDR_LEN) || ver_nib != IP_VERSION_4)
         return r;
      l4_ofs = int'(ETH_HDR_LEN) + int'(ihl_len);
      if (ihl_len < MIN_HDR_LEN || l4_ofs > frame_len) return r;
      pay_ofs = l4_ofs;
      if (proto_acc == PROTO_TCP) begin
         if (l4_ofs + MIN_HDR_LEN > frame_len || tcp_hdr_len < MIN_HDR_LEN ||
             l4_ofs + tcp_hdr_len > frame_len)
            return r;
         r.status = STAT_TCP;
         pay_ofs = l4_ofs + tcp_hdr_len;
         r.sequence_number = seq_acc;
         r.ack_num = ack_acc;
         r.flag_bits = flags_acc;
      end else if (proto_acc == PROTO_UDP) begin
         if (l4_ofs + UDP_HDR_LEN > frame_len) return r;
         r.status = STAT_UDP;
         pay_ofs = l4_ofs + UDP_HDR_LEN;
      end else begin
         r.status = STAT_IPV4_OTHER;
      end
      r.eth_type = etype_acc;
      r.ip_protocol = proto_acc;
      r.source_address = src_acc;
      r.dest_address = dst_acc;
      if (r.status == STAT_TCP || r.status == STAT_UDP) begin
         r.source_port = ports_acc[31:16];
         r.dest_port = ports_acc[15:0];
      end
      r.payload_start = pay_ofs[7:0];
      r.payload_bytes = (pay_ofs < frame_len) ? 16'(frame_len - pay_ofs) : 16'd0;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         if (errors < 10)
            $display("record %0d %s: expected 0x%0h, got 0x%0h", rec_no, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         record_q.delete();
         records_pending <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_byte(req_data_byte);
            if (req_end_of_packet) begin
               record_q.push_back(frame_record());
               clear_frame();
            end else if (frame_pos != POS_MAX) begin
               frame_pos++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (record_q.size() == 0) begin
               if (errors < 10) $display("record %0d arrived with none outstanding", rec_no);
               errors++;
            end else begin
               want_rec = record_q.pop_front();
               check_field("status", 32'(want_rec.status), 32'(rsp_status));
               check_field("eth_type", 32'(want_rec.eth_type), 32'(rsp_eth_type));
               check_field("ip_protocol", 32'(want_rec.ip_protocol), 32'(rsp_ip_protocol));
               check_field("source_address", want_rec.source_address, rsp_source_address);
               check_field("dest_address", want_rec.dest_address, rsp_dest_address);
               check_field("source_port", 32'(want_rec.source_port), 32'(rsp_source_port));
               check_field("dest_port", 32'(want_rec.dest_port), 32'(rsp_dest_port));
               check_field("sequence_number", want_rec.sequence_number,
                           rsp_sequence_number);
               check_field("ack_num", want_rec.ack_num, rsp_ack_num);
               check_field("flag_bits", 32'(want_rec.flag_bits), 32'(rsp_flag_bits));
               check_field("payload_start", 32'(want_rec.payload_start),
                           32'(rsp_payload_start));
               check_field("payload_bytes", 32'(want_rec.payload_bytes),
                           32'(rsp_payload_bytes));
            end
            rec_no++;
         end
         records_pending <= record_q.size();
      end
   end

endmodule

// ===== verif/tb_eth_ipv4_l4_header_parser.sv =====
// top-level testbench: frame stimulus, flow control and verdict for the header parser
`timescale 1ns / 1ps

module tb_eth_ipv4_l4_header_parser;
   import ehp_pkg::*;

   // protocol numbers and ethertypes used by the directed frames
   localparam logic [7:0]  PROTO_HOPOPT   = 8'd0;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_RESERVED = 8'd255;
   localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
   localparam logic [3:0]  IP_VERSION_6   = 4'd6;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_packet = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_eth_type;
   logic [7:0]  rsp_ip_protocol;
   logic [31:0] rsp_source_address;
   logic [31:0] rsp_dest_address;
   logic [15:0] rsp_source_port;
   logic [15:0] rsp_dest_port;
   logic [31:0] rsp_sequence_number;
   logic [31:0] rsp_ack_num;
   logic [7:0]  rsp_flag_bits;
   logic [7:0]  rsp_payload_start;
   logic [15:0] rsp_payload_bytes;

   int          error_count;
   int          records_pending;

   int unsigned cycle_no = 0;
   logic        quiet;
   logic [7:0]  frame_q[$];
   int unsigned rand_bytes = 0;
   int unsigned rand_frames = 0;

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // a recurring quiet window, the last quarter of each period of cycle_no: no gaps, no stalls
   always @(posedge clock) cycle_no <= cycle_no + 1;
   assign quiet = (cycle_no % 1024) >= 768;

   // record side stalls about a third of the time outside the quiet window
   always @(posedge clock)
      rsp_stall <= !reset && !quiet && ($urandom_range(99) < 32);

   eth_ipv4_l4_header_parser i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_packet   (req_end_of_packet),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_eth_type        (rsp_eth_type),
      .rsp_ip_protocol     (rsp_ip_protocol),
      .rsp_source_address  (rsp_source_address),
      .rsp_dest_address    (rsp_dest_address),
      .rsp_source_port     (rsp_source_port),
      .rsp_dest_port       (rsp_dest_port),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_ack_num         (rsp_ack_num),
      .rsp_flag_bits       (rsp_flag_bits),
      .rsp_payload_start   (rsp_payload_start),
      .rsp_payload_bytes   (rsp_payload_bytes)
   );

   header_record_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_end_of_packet   (req_end_of_packet),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_eth_type        (rsp_eth_type),
      .rsp_ip_protocol     (rsp_ip_protocol),
      .rsp_source_address  (rsp_source_address),
      .rsp_dest_address    (rsp_dest_address),
      .rsp_source_port     (rsp_source_port),
      .rsp_dest_port       (rsp_dest_port),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_ack_num         (rsp_ack_num),
      .rsp_flag_bits       (rsp_flag_bits),
      .rsp_payload_start   (rsp_payload_start),
      .rsp_payload_bytes   (rsp_payload_bytes),
      .error_count         (error_count),
      .records_pending     (records_pending)
   );

   // offer one byte word, with a random gap first, and hold it until it is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!quiet && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_packet <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // random bytes with the header fields laid over them where the frame is long enough
   task automatic build_frame(input logic [15:0] etype, input logic [3:0] ver,
                              input logic [3:0] ihl, input logic [7:0] proto,
                              input logic [3:0] doff, input int unsigned len);
      int unsigned doff_ofs;
      frame_q.delete();
      for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
      if (len > 12) frame_q[12] = etype[15:8];
      if (len > 13) frame_q[13] = etype[7:0];
      if (len > 14) frame_q[14] = {ver, ihl};
      if (len > 23) frame_q[23] = proto;
      // data offset nibble, high half of transport header byte 12
      doff_ofs = int'(ETH_HDR_LEN) + int'(ihl) * 4 + 12;
      if (len > doff_ofs) frame_q[doff_ofs] = {doff, frame_q[doff_ofs][3:0]};
   endtask

   // hold the byte side until every outstanding record has come back
   task automatic drain_records();
      req_valid <= 1'b0;
      @(posedge clock);
      while (records_pending != 0) @(posedge clock);
   endtask

   task automatic directed_frames();
      // shortest possible frame, and one byte short of an ethernet header
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd5, 1);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd5, 13);
      send_frame();
      // ipv4 ethertype but no room for an ip header
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd5, 14);
      send_frame();
      // non-ip frames, including all-ones and all-zero content
      build_frame(ETYPE_IPV6, IP_VERSION_6, 4'd5, PROTO_TCP, 4'd5, 14);
      send_frame();
      build_frame(ETYPE_IPV6, IP_VERSION_6, 4'd5, PROTO_TCP, 4'd5, 20);
      foreach (frame_q[i]) frame_q[i] = 8'hFF;
      send_frame();
      build_frame(ETYPE_IPV6, IP_VERSION_6, 4'd5, PROTO_TCP, 4'd5, 20);
      foreach (frame_q[i]) frame_q[i] = 8'h00;
      send_frame();
      // wrong version, ihl below the minimum, ihl running past the frame
      build_frame(ETHERTYPE_IPV4, IP_VERSION_6, 4'd5, PROTO_TCP, 4'd5, 34);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd4, PROTO_UDP, 4'd5, 42);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd0, PROTO_UDP, 4'd5, 34);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd15, PROTO_TCP, 4'd15, 50);
      send_frame();
      // largest headers: ending exactly at the frame end, then with payload
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd15, PROTO_TCP, 4'd15, 134);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd15, PROTO_TCP, 4'd15, 140);
      send_frame();
      // minimal tcp, exact and with payload
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd5, 54);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd5, 64);
      send_frame();
      // tcp rejects: offset too small, header past the frame, no room for 20 bytes
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd4, 54);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd10, 60);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_TCP, 4'd5, 50);
      send_frame();
      // udp: exact header, one byte short, with payload
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 4'd5, 42);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_UDP, 4'd5, 41);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd6, PROTO_UDP, 4'd5, 60);
      send_frame();
      // other protocols, payload straight after the ip header
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_ICMP, 4'd5, 34);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_RESERVED, 4'd5, 40);
      send_frame();
      build_frame(ETHERTYPE_IPV4, IP_VERSION_4, 4'd5, PROTO_HOPOPT, 4'd5, 40);
      send_frame();
   endtask

   task automatic random_frames();
      int unsigned pick;
      logic [15:0] etype;
      logic [3:0]  ver;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      logic [3:0]  doff;
      int unsigned l4_len;
      int unsigned hdr_len;
      int unsigned len;
      while (rand_bytes < 150 || rand_frames < 3) begin
         pick = $urandom_range(99);
         etype = (pick < 12) ? 16'($urandom) : ETHERTYPE_IPV4;
         ver = ($urandom_range(9) == 0) ? 4'($urandom) : IP_VERSION_4;
         ihl = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
         case ($urandom_range(9))
            0, 1, 2, 3: proto = PROTO_TCP;
            4, 5, 6:    proto = PROTO_UDP;
            default:    proto = 8'($urandom);
         endcase
         doff = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd5;
         l4_len = (proto == PROTO_TCP) ? int'(doff) * 4 : int'(UDP_HDR_LEN);
         hdr_len = int'(ETH_HDR_LEN) + int'(ihl) * 4 + l4_len;
         // mostly well-formed lengths, some truncated
         if ($urandom_range(7) == 0) len = $urandom_range(hdr_len + 2, 1);
         else len = hdr_len + $urandom_range(40, 0);
         if (pick >= 95) begin
            // pure noise
            build_frame(16'($urandom), 4'($urandom), 4'($urandom), 8'($urandom),
                        4'($urandom), $urandom_range(80, 1));
         end else begin
            build_frame(etype, ver, ihl, proto, doff, len);
         end
         rand_bytes += frame_q.size();
         rand_frames++;
         send_frame();
         if ($urandom_range(15) == 0) drain_records();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      directed_frames();
      // let the pipe run dry once before the random part
      drain_records();
      random_frames();
      drain_records();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
